// ===== src/ntp_pkg.sv =====
// shared types, sizes and register codes of the peak normalizer
package ntp_pkg;

   // frame store geometry
   localparam int FRAME_DEPTH = 64;
   localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
   localparam int NUM_BANKS   = 2;
   localparam int BANK_W      = $clog2(NUM_BANKS);
   localparam int MEM_AW      = ADDR_W + BANK_W;
   localparam int QCNT_W      = $clog2(NUM_BANKS + 1);

   // field widths
   localparam int SAMPLE_W  = 24;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 2;

   // datapath widths: product, numerator 2p+d, its magnitude, divider
   localparam int PROD_W = 57;
   localparam int NUM_W  = 58;
   localparam int MAG_W  = 57;
   localparam int QBITS  = 33;
   localparam int DIV_W  = 25;
   localparam int QV_W   = 35;
   localparam int RSUM_W = 36;
   localparam int DCNT_W = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK   = 2'd2;

   // register reset values
   localparam logic [DATA_W-1:0]   SCALE_RESET  = 32'h0001_0000;
   localparam logic [DATA_W-1:0]   OFFSET_RESET = 32'h0000_0000;
   localparam logic [SAMPLE_W-1:0] PEAK_RESET   = 24'h00_0000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] normalized;
      logic                     run_end;
      logic                     zero_divisor;
      logic                     overflowed;
   } rsp_type;

   // one closed frame waiting for emission
   typedef struct packed {
      logic [BANK_W-1:0]   bank;
      logic [CNT_W-1:0]    count;
      logic [SAMPLE_W-1:0] divisor;
      logic                dropped;
   } job_type;

   // store write from the loader
   typedef struct packed {
      logic                en;
      logic [MEM_AW-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } mem_wr_type;

endpackage

// ===== src/ntp_queue.sv =====
// two-entry queue of closed frames between loader and emitter
module ntp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ntp_pkg::job_type push_job,
   input  logic             pop,
   output ntp_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   ntp_pkg::job_type                    entry_ff [ntp_pkg::NUM_BANKS];
   logic [ntp_pkg::BANK_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [ntp_pkg::BANK_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [ntp_pkg::QCNT_W-1:0]          count_ff, count_in;

   assign full  = (count_ff == ntp_pkg::QCNT_W'(ntp_pkg::NUM_BANKS));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("frame queue pushed while full");

endmodule

// ===== src/ntp_front.sv =====
// loader: stores samples, tracks the frame maximum and closes frames
module ntp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ntp_pkg::req_type              req_data,
   input  logic [ntp_pkg::SAMPLE_W-1:0]  peak,
   input  logic                          q_full,
   output logic                          push,
   output ntp_pkg::job_type              push_job,
   output ntp_pkg::mem_wr_type           wr
);

   logic [ntp_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [ntp_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic                         drop_ff, drop_in;
   logic [ntp_pkg::BANK_W-1:0]   bank_ff, bank_in;

   logic                         accept;
   logic                         has_room;
   logic                         store;
   logic [ntp_pkg::CNT_W-1:0]    fill_upd;
   logic [ntp_pkg::SAMPLE_W-1:0] max_upd;
   logic                         drop_upd;

   // a bank is free whenever the queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign has_room  = (fill_ff != ntp_pkg::CNT_W'(ntp_pkg::FRAME_DEPTH));
   assign store     = accept && has_room;

   // frame bookkeeping
   always_comb begin
      fill_upd = store ? fill_ff + 1'b1 : fill_ff;
      max_upd  = (store && (req_data.sample > max_ff)) ? req_data.sample : max_ff;
      drop_upd = drop_ff | (accept && !has_room);

      push             = accept && req_data.frame_end;
      push_job.bank    = bank_ff;
      push_job.count   = fill_upd;
      push_job.divisor = (peak != '0) ? peak : max_upd;
      push_job.dropped = drop_upd;

      fill_in = fill_upd;
      max_in  = max_upd;
      drop_in = drop_upd;
      bank_in = bank_ff;
      if (push) begin
         fill_in = '0;
         max_in  = '0;
         drop_in = 1'b0;
         bank_in = bank_ff + 1'b1;
      end
   end

   // store write
   always_comb begin
      wr.en   = store;
      wr.addr = {bank_ff, fill_ff[ntp_pkg::ADDR_W-1:0]};
      wr.data = req_data.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         max_ff  <= '0;
         drop_ff <= 1'b0;
         bank_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         max_ff  <= max_in;
         drop_ff <= drop_in;
         bank_ff <= bank_in;
      end
   end

endmodule

// ===== src/ntp_back.sv =====
// emitter: sample store, multiply, bit-serial divide, offset and saturate
module ntp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ntp_pkg::mem_wr_type         wr,
   input  logic                        q_empty,
   input  ntp_pkg::job_type            head,
   output logic                        q_pop,
   input  logic [ntp_pkg::DATA_W-1:0]  scale,
   input  logic [ntp_pkg::DATA_W-1:0]  offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ntp_pkg::rsp_type            rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_SAT  = 3'd6;
   localparam logic [2:0] ST_ERR  = 3'd7;

   localparam logic signed [ntp_pkg::RSUM_W-1:0] R_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [ntp_pkg::RSUM_W-1:0] R_MIN = 36'shF_8000_0000;
   localparam logic [ntp_pkg::DATA_W-1:0]        O_MAX = 32'h7FFF_FFFF;
   localparam logic [ntp_pkg::DATA_W-1:0]        O_MIN = 32'h8000_0000;

   logic [ntp_pkg::SAMPLE_W-1:0] mem [2**ntp_pkg::MEM_AW];

   logic [2:0]                          state_ff, state_in;
   logic [ntp_pkg::CNT_W-1:0]           idx_ff, idx_in;
   logic [ntp_pkg::MEM_AW-1:0]          rd_addr_ff, rd_addr_in;
   logic [ntp_pkg::SAMPLE_W-1:0]        rd_data_ff;
   logic signed [ntp_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic                                ovf_ff, ovf_in;
   logic [ntp_pkg::DIV_W-1:0]           rem_ff, rem_in;
   logic [ntp_pkg::QBITS-1:0]           quo_ff, quo_in;
   logic [ntp_pkg::DCNT_W-1:0]          dcnt_ff, dcnt_in;
   logic [ntp_pkg::QV_W-1:0]            qv_ff, qv_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ntp_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic [ntp_pkg::DIV_W-1:0]   m_div;
   logic [ntp_pkg::NUM_W-1:0]   num;
   logic [ntp_pkg::NUM_W-1:0]   num_abs;
   logic [ntp_pkg::MAG_W-1:0]   mag;
   logic [ntp_pkg::DIV_W:0]     trial;
   logic [ntp_pkg::DIV_W:0]     diff;
   logic                        fits;
   logic [ntp_pkg::QBITS:0]     qmag;
   logic [ntp_pkg::RSUM_W-1:0]  rsum;
   logic [ntp_pkg::DATA_W-1:0]  sat_val;
   logic                        out_free;
   logic                        last;
   logic                        load_out;

   // sample store, read data registered
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   // arithmetic
   always_comb begin
      m_div   = {head.divisor, 1'b0};
      prod_in = $signed({{(ntp_pkg::PROD_W - ntp_pkg::DATA_W){scale[ntp_pkg::DATA_W-1]}},
                         scale})
              * $signed({{(ntp_pkg::PROD_W - ntp_pkg::SAMPLE_W){1'b0}}, rd_data_ff});
      num     = {prod_ff, 1'b0}
              + {{(ntp_pkg::NUM_W - ntp_pkg::SAMPLE_W){1'b0}}, head.divisor};
      num_abs = num[ntp_pkg::NUM_W-1] ? (~num + 1'b1) : num;
      mag     = num_abs[ntp_pkg::MAG_W-1:0];

      // one restoring step per cycle
      trial = {rem_ff, quo_ff[ntp_pkg::QBITS-1]};
      diff  = trial - {1'b0, m_div};
      fits  = (trial >= {1'b0, m_div});

      // floor for negative numerators rounds the magnitude up
      qmag = {1'b0, quo_ff} + {{ntp_pkg::QBITS{1'b0}}, (neg_ff && (rem_ff != '0))};

      rsum = {qv_ff[ntp_pkg::QV_W-1], qv_ff}
           + {{(ntp_pkg::RSUM_W - ntp_pkg::DATA_W){offset[ntp_pkg::DATA_W-1]}}, offset};
      if (ovf_ff) begin
         sat_val = neg_ff ? O_MIN : O_MAX;
      end else if ($signed(rsum) > R_MAX) begin
         sat_val = O_MAX;
      end else if ($signed(rsum) < R_MIN) begin
         sat_val = O_MIN;
      end else begin
         sat_val = rsum[ntp_pkg::DATA_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last     = ((idx_ff + 1'b1) == head.count);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_addr_in   = rd_addr_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      qv_in        = qv_ff;
      q_pop        = 1'b0;
      load_out     = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (head.divisor == '0) begin
                  state_in = ST_ERR;
               end else begin
                  idx_in     = '0;
                  rd_addr_in = {head.bank, {ntp_pkg::ADDR_W{1'b0}}};
                  state_in   = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            neg_in   = num[ntp_pkg::NUM_W-1];
            ovf_in   = ({1'b0, mag[ntp_pkg::MAG_W-1:ntp_pkg::QBITS]} >= m_div);
            rem_in   = {1'b0, mag[ntp_pkg::MAG_W-1:ntp_pkg::QBITS]};
            quo_in   = mag[ntp_pkg::QBITS-1:0];
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? diff[ntp_pkg::DIV_W-1:0] : trial[ntp_pkg::DIV_W-1:0];
            quo_in  = {quo_ff[ntp_pkg::QBITS-2:0], fits};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == ntp_pkg::DCNT_W'(ntp_pkg::QBITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            qv_in    = neg_ff ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (out_free) begin
               load_out                 = 1'b1;
               rsp_data_in.normalized   = sat_val;
               rsp_data_in.run_end      = last;
               rsp_data_in.zero_divisor = 1'b0;
               rsp_data_in.overflowed   = head.dropped;
               if (last) begin
                  q_pop    = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  rd_addr_in = {head.bank, idx_in[ntp_pkg::ADDR_W-1:0]};
                  state_in   = ST_LOAD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               load_out                 = 1'b1;
               rsp_data_in.normalized   = '0;
               rsp_data_in.run_end      = 1'b1;
               rsp_data_in.zero_divisor = 1'b1;
               rsp_data_in.overflowed   = head.dropped;
               q_pop                    = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
         idx_ff       <= '0;
         rd_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
         idx_ff       <= idx_in;
         rd_addr_ff   <= rd_addr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      qv_ff       <= qv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("frame popped from empty queue");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff < ntp_pkg::DCNT_W'(ntp_pkg::QBITS)))
      else $error("divide step count out of range");

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.zero_divisor) |-> rsp_data_ff.run_end)
      else $error("zero divisor result without run end");

endmodule

// ===== src/normalize_to_peak.sv =====
// top level of the peak normalizer: registers, loader, frame queue, emitter
//
//   channel   direction  ports                            moves
//   request   in         req_valid req_ready req_data     one sample, frame end mark
//   response  out        rsp_valid rsp_ready rsp_data     one normalized value, flags
//   csr       in         csr_we csr_index csr_wdata       scale, offset, peak writes
//
// while requests are not stalled, loading takes one sample per cycle into one bank of a two-bank sample store
// each stored sample is then emitted in steps: read, 32x24 multiply, prep,
// a one-bit-per-cycle divider, round, offset and saturate
// a zero divisor frame gives a single result with zero divisor and run end set
// requests stall only while both banks hold closed frames awaiting emission
// reset is synchronous, active high; registers return to scale 1.0, offset 0, peak 0
module normalize_to_peak (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ntp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ntp_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [ntp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ntp_pkg::DATA_W-1:0]      csr_wdata
);

   logic [ntp_pkg::DATA_W-1:0]   scale_ff, scale_in;
   logic [ntp_pkg::DATA_W-1:0]   offset_ff, offset_in;
   logic [ntp_pkg::SAMPLE_W-1:0] peak_ff, peak_in;

   logic                         push;
   logic                         pop;
   logic                         q_full;
   logic                         q_empty;
   ntp_pkg::job_type             push_job;
   ntp_pkg::job_type             head;
   ntp_pkg::mem_wr_type          wr;

   // configuration registers
   always_comb begin
      scale_in  = scale_ff;
      offset_in = offset_ff;
      peak_in   = peak_ff;
      if (csr_we) begin
         case (csr_index)
            ntp_pkg::CSR_SCALE:  scale_in  = csr_wdata;
            ntp_pkg::CSR_OFFSET: offset_in = csr_wdata;
            ntp_pkg::CSR_PEAK:   peak_in   = csr_wdata[ntp_pkg::SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= ntp_pkg::SCALE_RESET;
         offset_ff <= ntp_pkg::OFFSET_RESET;
         peak_ff   <= ntp_pkg::PEAK_RESET;
      end else begin
         scale_ff  <= scale_in;
         offset_ff <= offset_in;
         peak_ff   <= peak_in;
      end
   end

   // loader
   ntp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .peak      (peak_ff),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job),
      .wr        (wr)
   );

   // closed frames
   ntp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // emitter
   ntp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .q_empty   (q_empty),
      .head      (head),
      .q_pop     (pop),
      .scale     (scale_ff),
      .offset    (offset_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
